### rtl/rgbled_pkg.sv
// ---------------------------------------------------------------------------
// rgbled_pkg
// Shared types, codes and helpers for the RGB status LED pattern sequencer.
// ---------------------------------------------------------------------------
package rgbled_pkg;

   // width of the step tick down-counter
   localparam int TICK_BITS   = 16;
   localparam int PERIOD_BITS = 16;
   localparam int LEVEL_BITS  = 7;
   localparam int WIDE_BITS   = (TICK_BITS > PERIOD_BITS) ? TICK_BITS : PERIOD_BITS;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = PERIOD_BITS;

   localparam int REQ_USER_BITS = 2;
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 8;

   localparam logic [3:0] BATT_STEPS   = 4'd12;
   localparam logic [3:0] TRIPLE_STEPS = 4'd6;
   localparam logic [3:0] CHECK_STEPS  = 4'd7;

   typedef enum logic [1:0] {
      ACT_TICK   = 2'd0,
      ACT_CMD    = 2'd1,
      ACT_REPORT = 2'd2
   } action_type;

   typedef enum logic [3:0] {
      CMD_BATT         = 4'd0,
      CMD_CHECK        = 4'd1,
      CMD_TRIPLE_WHITE = 4'd2,
      CMD_TRIPLE_GREEN = 4'd3,
      CMD_SINGLE_GREEN = 4'd4,
      CMD_SINGLE_BLUE  = 4'd5,
      CMD_TRIPLE_BLUE  = 4'd6,
      CMD_TRIPLE_RED   = 4'd7,
      CMD_ARM_NUMLOCK  = 4'd8
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_NONE   = 3'd0,
      KIND_BATT   = 3'd1,
      KIND_CHECK  = 3'd2,
      KIND_TRIPLE = 3'd3,
      KIND_SINGLE = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      COL_OFF    = 3'd0,
      COL_RED    = 3'd1,
      COL_GREEN  = 3'd2,
      COL_BLUE   = 3'd3,
      COL_YELLOW = 3'd4,
      COL_CYAN   = 3'd5,
      COL_PURPLE = 3'd6,
      COL_WHITE  = 3'd7
   } colour_type;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_BLINK_PERIOD  = 3'd0,
      CSR_CHECK_PERIOD  = 3'd1,
      CSR_TRIPLE_PERIOD = 3'd2,
      CSR_SINGLE_PERIOD = 3'd3,
      CSR_HIGH_LEVEL    = 3'd4,
      CSR_MID_LEVEL     = 3'd5,
      CSR_LOW_LEVEL     = 3'd6
   } csr_addr_type;

   typedef struct packed {
      logic [PERIOD_BITS-1:0] blink_period;
      logic [PERIOD_BITS-1:0] check_period;
      logic [PERIOD_BITS-1:0] triple_period;
      logic [PERIOD_BITS-1:0] single_period;
      logic [LEVEL_BITS-1:0]  high_level;
      logic [LEVEL_BITS-1:0]  mid_level;
      logic [LEVEL_BITS-1:0]  low_level;
   } cfg_type;

   typedef struct packed {
      logic [7:0]            indicators;
      logic [LEVEL_BITS-1:0] battery_percent;
      logic [3:0]            mode;
      logic [1:0]            action;
   } item_type;

   typedef struct packed {
      logic numlock_state;
      logic busy_res;
      logic blue_on;
      logic green_on;
      logic red_on;
   } result_type;

   // LED bits of a colour: bit0 red, bit1 green, bit2 blue
   function automatic logic [2:0] colour_bits(colour_type c);
      logic [2:0] b;
      unique case (c)
         COL_OFF:    b = 3'b000;
         COL_RED:    b = 3'b001;
         COL_GREEN:  b = 3'b010;
         COL_BLUE:   b = 3'b100;
         COL_YELLOW: b = 3'b011;
         COL_CYAN:   b = 3'b110;
         COL_PURPLE: b = 3'b101;
         COL_WHITE:  b = 3'b111;
         default:    b = 3'b000;
      endcase
      return b;
   endfunction

   function automatic colour_type check_colour(logic [2:0] step);
      colour_type c;
      unique case (step)
         3'd0:    c = COL_WHITE;
         3'd1:    c = COL_RED;
         3'd2:    c = COL_GREEN;
         3'd3:    c = COL_BLUE;
         3'd4:    c = COL_YELLOW;
         3'd5:    c = COL_CYAN;
         3'd6:    c = COL_PURPLE;
         default: c = COL_OFF;
      endcase
      return c;
   endfunction

   // zero acts as one; saturate to the counter width
   function automatic logic [TICK_BITS-1:0] load_ticks(logic [PERIOD_BITS-1:0] period);
      logic [WIDE_BITS-1:0] pw;
      logic [WIDE_BITS-1:0] maxw;
      pw   = WIDE_BITS'(period);
      maxw = WIDE_BITS'({TICK_BITS{1'b1}});
      if (pw == '0) begin
         pw = WIDE_BITS'(1);
      end
      if (pw > maxw) begin
         pw = maxw;
      end
      return pw[TICK_BITS-1:0];
   endfunction

endpackage

### rtl/rgbled_csr.sv
// ---------------------------------------------------------------------------
// rgbled_csr
// Configuration registers: step periods and battery thresholds.
// ---------------------------------------------------------------------------
module rgbled_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [rgbled_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [rgbled_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output rgbled_pkg::cfg_type                 cfg
);
   import rgbled_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr_type'(csr_addr))
            CSR_BLINK_PERIOD:  cfg_in.blink_period  = csr_wdata;
            CSR_CHECK_PERIOD:  cfg_in.check_period  = csr_wdata;
            CSR_TRIPLE_PERIOD: cfg_in.triple_period = csr_wdata;
            CSR_SINGLE_PERIOD: cfg_in.single_period = csr_wdata;
            CSR_HIGH_LEVEL:    cfg_in.high_level    = csr_wdata[LEVEL_BITS-1:0];
            CSR_MID_LEVEL:     cfg_in.mid_level     = csr_wdata[LEVEL_BITS-1:0];
            CSR_LOW_LEVEL:     cfg_in.low_level     = csr_wdata[LEVEL_BITS-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.blink_period  <= PERIOD_BITS'(250);
         cfg_ff.check_period  <= PERIOD_BITS'(500);
         cfg_ff.triple_period <= PERIOD_BITS'(120);
         cfg_ff.single_period <= PERIOD_BITS'(350);
         cfg_ff.high_level    <= LEVEL_BITS'(90);
         cfg_ff.mid_level     <= LEVEL_BITS'(50);
         cfg_ff.low_level     <= LEVEL_BITS'(20);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/rgbled_seq.sv
// ---------------------------------------------------------------------------
// rgbled_seq
// Pattern state and its one-item update: tick count-down, step advance,
// command decode and NumLock feedback.
// ---------------------------------------------------------------------------
module rgbled_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  rgbled_pkg::item_type   item,
   input  rgbled_pkg::cfg_type    cfg,
   output rgbled_pkg::result_type result
);
   import rgbled_pkg::*;

   kind_type               kind_ff,   kind_in;
   colour_type             colour_ff, colour_in;
   logic [3:0]             step_ff,   step_in;
   logic [TICK_BITS-1:0]   ticks_ff,  ticks_in;
   logic                   armed_ff,  armed_in;
   logic                   seen_ff,   seen_in;
   logic [2:0]             led_ff,    led_in;

   logic                   do_start;
   logic                   do_adv;
   kind_type               start_kind;
   colour_type             start_colour;
   colour_type             batt_colour;
   logic [3:0]             limit;
   logic [PERIOD_BITS-1:0] period;

   always_comb begin
      priority if (item.battery_percent >= cfg.high_level) begin
         batt_colour = COL_BLUE;
      end else if (item.battery_percent >= cfg.mid_level) begin
         batt_colour = COL_GREEN;
      end else if (item.battery_percent >= cfg.low_level) begin
         batt_colour = COL_YELLOW;
      end else begin
         batt_colour = COL_RED;
      end
   end

   always_comb begin
      kind_in      = kind_ff;
      colour_in    = colour_ff;
      step_in      = step_ff;
      ticks_in     = ticks_ff;
      armed_in     = armed_ff;
      seen_in      = seen_ff;
      led_in       = led_ff;
      do_start     = 1'b0;
      do_adv       = 1'b0;
      start_kind   = KIND_NONE;
      start_colour = COL_OFF;
      limit        = BATT_STEPS;
      period       = cfg.blink_period;

      unique case (action_type'(item.action))
         ACT_TICK: begin
            if (kind_ff != KIND_NONE) begin
               if (ticks_ff <= TICK_BITS'(1)) begin
                  do_adv = 1'b1;
               end else begin
                  ticks_in = ticks_ff - TICK_BITS'(1);
               end
            end
         end
         ACT_CMD: begin
            do_start = 1'b1;
            unique case (item.mode)
               CMD_BATT: begin
                  start_kind = KIND_BATT; start_colour = batt_colour;
               end
               CMD_CHECK: begin
                  start_kind = KIND_CHECK; start_colour = COL_WHITE;
               end
               CMD_TRIPLE_WHITE: begin
                  start_kind = KIND_TRIPLE; start_colour = COL_WHITE;
               end
               CMD_TRIPLE_GREEN: begin
                  start_kind = KIND_TRIPLE; start_colour = COL_GREEN;
               end
               CMD_SINGLE_GREEN: begin
                  start_kind = KIND_SINGLE; start_colour = COL_GREEN;
               end
               CMD_SINGLE_BLUE: begin
                  start_kind = KIND_SINGLE; start_colour = COL_BLUE;
               end
               CMD_TRIPLE_BLUE: begin
                  start_kind = KIND_TRIPLE; start_colour = COL_BLUE;
               end
               CMD_TRIPLE_RED: begin
                  start_kind = KIND_TRIPLE; start_colour = COL_RED;
               end
               CMD_ARM_NUMLOCK: begin
                  do_start = 1'b0;
                  armed_in = 1'b1;
               end
               default: begin
                  start_kind = KIND_SINGLE; start_colour = COL_RED;
               end
            endcase
         end
         ACT_REPORT: begin
            seen_in = item.indicators[0];
            if (armed_ff) begin
               armed_in     = 1'b0;
               do_start     = 1'b1;
               start_kind   = KIND_TRIPLE;
               start_colour = item.indicators[0] ? COL_RED : COL_GREEN;
            end
         end
         default: begin
         end
      endcase

      // a new pattern shows its first step at once
      if (do_start) begin
         kind_in   = start_kind;
         colour_in = start_colour;
         step_in   = '0;
         do_adv    = 1'b1;
      end

      if (do_adv) begin
         unique case (kind_in)
            KIND_BATT, KIND_TRIPLE: begin
               if (kind_in == KIND_TRIPLE) begin
                  limit  = TRIPLE_STEPS;
                  period = cfg.triple_period;
               end
               if (step_in >= limit) begin
                  led_in = 3'b000; kind_in = KIND_NONE; ticks_in = '0;
               end else begin
                  led_in   = step_in[0] ? 3'b000 : colour_bits(colour_in);
                  step_in  = step_in + 4'd1;
                  ticks_in = load_ticks(period);
               end
            end
            KIND_CHECK: begin
               if (step_in >= CHECK_STEPS) begin
                  led_in = 3'b000; kind_in = KIND_NONE; ticks_in = '0;
               end else begin
                  led_in   = colour_bits(check_colour(step_in[2:0]));
                  step_in  = step_in + 4'd1;
                  ticks_in = load_ticks(cfg.check_period);
               end
            end
            KIND_SINGLE: begin
               if (step_in == '0) begin
                  led_in   = colour_bits(colour_in);
                  step_in  = 4'd1;
                  ticks_in = load_ticks(cfg.single_period);
               end else begin
                  led_in = 3'b000; kind_in = KIND_NONE; ticks_in = '0;
               end
            end
            default: begin
               led_in = 3'b000; kind_in = KIND_NONE; ticks_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= KIND_NONE;
         colour_ff <= COL_OFF;
         step_ff   <= '0;
         ticks_ff  <= '0;
         armed_ff  <= 1'b0;
         seen_ff   <= 1'b0;
         led_ff    <= 3'b000;
      end else if (step_en) begin
         kind_ff   <= kind_in;
         colour_ff <= colour_in;
         step_ff   <= step_in;
         ticks_ff  <= ticks_in;
         armed_ff  <= armed_in;
         seen_ff   <= seen_in;
         led_ff    <= led_in;
      end
   end

   // state after this item
   assign result.red_on        = led_in[0];
   assign result.green_on      = led_in[1];
   assign result.blue_on       = led_in[2];
   assign result.busy_res      = (kind_in != KIND_NONE);
   assign result.numlock_state = seen_in;

endmodule

### rtl/rgb_status_led_pattern_sequencer_unit.sv
// ---------------------------------------------------------------------------
// rgb_status_led_pattern_sequencer_unit
// RGB status LED sequencer: ticks, commands and host reports in, LED state out.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one item per transfer: a time tick, a command code or a
//   host indicator report, the kind of item on req_tuser. Every item produces
//   exactly one rsp_* transfer with the LED state, busy flag and NumLock
//   state after that item.
//   csr_* writes the step periods and battery thresholds; write only while
//   no item is in flight.
// Path: an item taken on req_* passes through the input register, then the
//   result register loaded by the sequencer update, before it shows on rsp_*.
// Throughput: one item per cycle unless rsp_tready stalls; the pattern state
//   update is combinational, so back-to-back items chain through its registers.
// Stall: when rsp_tready is low with a result pending, the result register
//   holds; the input register still takes one more item, then req_tready drops.
// Reset: synchronous, active high; no pattern runs, LEDs off, NumLock flags
//   cleared, registers return to their default periods and thresholds.
// ---------------------------------------------------------------------------
module rgb_status_led_pattern_sequencer_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // tuser: action[1:0]
   input  logic [rgbled_pkg::REQ_USER_BITS-1:0] req_tuser,
   // tdata: mode[3:0], battery_percent[10:4], indicators[18:11]
   input  logic [rgbled_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // tdata: red_on[0], green_on[1], blue_on[2], busy_res[3], numlock_state[4]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [rgbled_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic                                 csr_we,
   input  logic [rgbled_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [rgbled_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import rgbled_pkg::*;

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   item_type   req_item;
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff;
   result_type seq_res;
   cfg_type    cfg;
   logic       step_en;
   logic       req_fire;

   assign req_item.action          = req_tuser;
   assign req_item.mode            = req_tdata[3:0];
   assign req_item.battery_percent = req_tdata[10:4];
   assign req_item.indicators      = req_tdata[18:11];

   assign step_en     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || step_en;
   assign req_fire    = req_tvalid && req_tready;
   assign in_valid_in = req_fire || (in_valid_ff && !step_en);
   assign out_valid_in = step_en || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_item;
      end
      if (step_en) begin
         out_res_ff <= seq_res;
      end
   end

   rgbled_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rgbled_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (seq_res)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_res_ff};

   // idle sequencer never lights an LED
   a_idle_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[3]) |-> (rsp_tdata[2:0] == 3'b000))
      else $error("LED lit while no pattern runs");

   // a buffered item moves to the result register when it has room
   a_item_moves: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && (!rsp_tvalid || rsp_tready)) |=> rsp_tvalid)
      else $error("buffered item not delivered");

   // an empty result register never back-pressures the input
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   // a stalled result holds its value
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

endmodule
